/* src/mfs_pkg.sv */
// Shared definitions for the motor fault supervisor: field widths, fault code words,
// register map and configuration reset values. No dependencies.
package mfs_pkg;

	localparam int unsigned ErrW  = 16;
	localparam int unsigned RpmW  = 13;
	localparam int unsigned TempW = 8;
	localparam int unsigned CurW  = 10;
	localparam int unsigned PubW  = 4;
	localparam int unsigned CntW  = 3;
	localparam int unsigned SlimW = 12;
	localparam int unsigned ClimW = 9;
	localparam int unsigned AddrW = 5;
	localparam int unsigned DataW = 32;

	// Critical fault codes
	localparam logic [ErrW-1:0] CodeEncErr   = 16'h0800;
	localparam logic [ErrW-1:0] CodeEncTol   = 16'h0020;
	localparam logic [ErrW-1:0] CodeVref     = 16'h0080;
	localparam logic [ErrW-1:0] CodeHall     = 16'h0200;
	// Recoverable fault codes
	localparam logic [ErrW-1:0] CodeOverV    = 16'h0001;
	localparam logic [ErrW-1:0] CodeUnderV   = 16'h0002;
	localparam logic [ErrW-1:0] CodeOverI    = 16'h0004;
	localparam logic [ErrW-1:0] CodeOverload = 16'h0008;
	localparam logic [ErrW-1:0] CodeEeprom   = 16'h0100;
	// Latched fault codes
	localparam logic [ErrW-1:0] CodeSpeed    = 16'h2000;
	localparam logic [ErrW-1:0] CodeHeat     = 16'h0400;

	localparam logic [CntW-1:0]  CntMax = 3'd7;
	localparam logic [PubW-1:0]  PubLegal = 4'd1;

	localparam logic [CntW-1:0]         RstRecLimit = 3'd5;
	localparam logic [SlimW-1:0]        RstSpeedLimit = 12'd2500;
	localparam logic signed [TempW-1:0] RstTempHigh = 8'sd85;
	localparam logic signed [TempW-1:0] RstTempLow = 8'sd60;
	localparam logic signed [TempW-1:0] RstTempCrit = 8'sd100;
	localparam logic [ClimW-1:0]        RstCurLimit = 9'd250;

	typedef enum logic [2:0] {
		REG_REC_LIMIT   = 3'd0,
		REG_SPEED_LIMIT = 3'd1,
		REG_TEMP_HIGH   = 3'd2,
		REG_TEMP_LOW    = 3'd3,
		REG_TEMP_CRIT   = 3'd4,
		REG_CUR_LIMIT   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [ErrW-1:0]         err_left;
		logic [ErrW-1:0]         err_right;
		logic signed [RpmW-1:0]  rpm_l;
		logic signed [RpmW-1:0]  rpm_r;
		logic signed [TempW-1:0] temp_l;
		logic signed [TempW-1:0] temp_r;
		logic signed [CurW-1:0]  cur_l;
		logic signed [CurW-1:0]  cur_r;
		logic [PubW-1:0]         publisher_count;
	} in_item_t;

	typedef struct packed {
		logic            estop;
		logic            publisher_stop;
		logic            halted;
		logic            slow_down;
		logic            restore_ramps;
		logic            parking_on;
		logic            parking_off;
		logic            reset_and_enable;
		logic            warn_temperature;
		logic            warn_speed;
		logic            warn_current;
		logic [CntW-1:0] fault_count;
	} out_item_t;

endpackage

/* src/mfs_if.sv */
// Request channels of the motor fault supervisor: tick readings in, supervisor actions out.
// Depends on mfs_pkg for field widths.
interface mfs_in_if;
	import mfs_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [ErrW-1:0]         err_left;
	logic [ErrW-1:0]         err_right;
	logic signed [RpmW-1:0]  rpm_l;
	logic signed [RpmW-1:0]  rpm_r;
	logic signed [TempW-1:0] temp_l;
	logic signed [TempW-1:0] temp_r;
	logic signed [CurW-1:0]  cur_l;
	logic signed [CurW-1:0]  cur_r;
	logic [PubW-1:0]         publisher_count;

	modport source (output valid, err_left, err_right, rpm_l, rpm_r, temp_l,
		temp_r, cur_l, cur_r, publisher_count, input ready);
	modport sink (input valid, err_left, err_right, rpm_l, rpm_r, temp_l,
		temp_r, cur_l, cur_r, publisher_count, output ready);
endinterface

interface mfs_out_if;
	import mfs_pkg::*;
	logic            valid;
	logic            ready;
	logic            estop;
	logic            publisher_stop;
	logic            halted;
	logic            slow_down;
	logic            restore_ramps;
	logic            parking_on;
	logic            parking_off;
	logic            reset_and_enable;
	logic            warn_temperature;
	logic            warn_speed;
	logic            warn_current;
	logic [CntW-1:0] fault_count;

	modport source (output valid, estop, publisher_stop, halted, slow_down,
		restore_ramps, parking_on, parking_off, reset_and_enable, warn_temperature,
		warn_speed, warn_current, fault_count, input ready);
	modport sink (input valid, estop, publisher_stop, halted, slow_down,
		restore_ramps, parking_on, parking_off, reset_and_enable, warn_temperature,
		warn_speed, warn_current, fault_count, output ready);
endinterface

/* src/motor_fault_supervisor_top.sv */
// Motor fault supervisor top level: input register, tick classification, result register.
// Depends on mfs_pkg and the request channel interfaces in mfs_if.sv.
//
// Usage: each monitor tick is one request on in_ch (fault codes, speeds, temperatures,
// currents, publisher count); each tick yields exactly one request on out_ch with the
// actions and warnings for that tick. Both channels move a request when valid and ready
// are high at a rising edge of clk.
// The result is registered: a tick passes the input register, then the result register.
// Throughput: one tick per cycle when not stalled; the fault latches and the recoverable
// count update as the tick moves into the result register, so the next tick sees them.
// Stall: while out_ch.ready is low the result holds; one more tick may be taken into the
// input register, after which in_ch.ready drops until the result is taken.
// Reset (arst_n low): latches, count and halt flag clear, thresholds return to their
// defaults, both stages empty. Once halted the block keeps answering each tick with
// halted set and the frozen count until the next reset. APB: registers at byte addresses
// 0x00..0x14, to be written only while no tick is in flight (the user's duty, unchecked).
module motor_fault_supervisor_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [mfs_pkg::AddrW-1:0] paddr,
	input  logic [mfs_pkg::DataW-1:0] pwdata,
	output logic [mfs_pkg::DataW-1:0] prdata,
	output logic                  pready,
	mfs_in_if.sink                in_ch,
	mfs_out_if.source             out_ch
);
	import mfs_pkg::*;

	logic [CntW-1:0]         rec_limit_q;
	logic [SlimW-1:0]        speed_limit_q;
	logic signed [TempW-1:0] temp_high_q;
	logic signed [TempW-1:0] temp_low_q;
	logic signed [TempW-1:0] temp_crit_q;
	logic [ClimW-1:0]        cur_limit_q;

	logic            ovh_q;
	logic            spd_q;
	logic [CntW-1:0] cnt_q;
	logic            halted_q;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_s2;
	logic      valid_s2;

	out_item_t       res_d;
	logic            ovh_d;
	logic            spd_d;
	logic [CntW-1:0] cnt_d;
	logic            halted_d;

	logic     advance;
	logic     cfg_wr;
	reg_idx_t cfg_idx;

	function automatic logic [RpmW-1:0] mag_rpm(input logic signed [RpmW-1:0] v);
		mag_rpm = v[RpmW-1] ? RpmW'(-v) : RpmW'(v);
	endfunction

	function automatic logic [CurW-1:0] mag_cur(input logic signed [CurW-1:0] v);
		mag_cur = v[CurW-1] ? CurW'(-v) : CurW'(v);
	endfunction

	function automatic logic either_is(input logic [ErrW-1:0] a, input logic [ErrW-1:0] b,
		input logic [ErrW-1:0] code);
		either_is = (a == code) || (b == code);
	endfunction

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[AddrW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_limit_q   <= RstRecLimit;
			speed_limit_q <= RstSpeedLimit;
			temp_high_q   <= RstTempHigh;
			temp_low_q    <= RstTempLow;
			temp_crit_q   <= RstTempCrit;
			cur_limit_q   <= RstCurLimit;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_REC_LIMIT:   rec_limit_q   <= pwdata[CntW-1:0];
				REG_SPEED_LIMIT: speed_limit_q <= pwdata[SlimW-1:0];
				REG_TEMP_HIGH:   temp_high_q   <= pwdata[TempW-1:0];
				REG_TEMP_LOW:    temp_low_q    <= pwdata[TempW-1:0];
				REG_TEMP_CRIT:   temp_crit_q   <= pwdata[TempW-1:0];
				REG_CUR_LIMIT:   cur_limit_q   <= pwdata[ClimW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_REC_LIMIT:   prdata = DataW'(rec_limit_q);
			REG_SPEED_LIMIT: prdata = DataW'(speed_limit_q);
			REG_TEMP_HIGH:   prdata = DataW'($unsigned(temp_high_q));
			REG_TEMP_LOW:    prdata = DataW'($unsigned(temp_low_q));
			REG_TEMP_CRIT:   prdata = DataW'($unsigned(temp_crit_q));
			REG_CUR_LIMIT:   prdata = DataW'(cur_limit_q);
			default:         prdata = '0;
		endcase
	end

	// Handshake
	assign advance      = !valid_s2 || out_ch.ready;
	assign in_ch.ready  = !valid_s1 || advance;

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.err_left        <= in_ch.err_left;
			item_s1.err_right       <= in_ch.err_right;
			item_s1.rpm_l           <= in_ch.rpm_l;
			item_s1.rpm_r           <= in_ch.rpm_r;
			item_s1.temp_l          <= in_ch.temp_l;
			item_s1.temp_r          <= in_ch.temp_r;
			item_s1.cur_l           <= in_ch.cur_l;
			item_s1.cur_r           <= in_ch.cur_r;
			item_s1.publisher_count <= in_ch.publisher_count;
		end
		if (advance && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ovh_q    <= 1'b0;
			spd_q    <= 1'b0;
			cnt_q    <= '0;
			halted_q <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (advance && valid_s1) begin
				ovh_q    <= ovh_d;
				spd_q    <= spd_d;
				cnt_q    <= cnt_d;
				halted_q <= halted_d;
			end
		end
	end

	// Tick classification
	always_comb begin
		logic [ErrW-1:0]         el;
		logic [ErrW-1:0]         er;
		logic [RpmW-1:0]         mrl;
		logic [RpmW-1:0]         mrr;
		logic [CurW-1:0]         mcl;
		logic [CurW-1:0]         mcr;
		logic signed [RpmW-1:0]  slim_s;
		logic [RpmW-1:0]         slim_u;
		logic [CurW-1:0]         clim_u;
		logic                    crit;
		logic                    recov;
		logic [CntW-1:0]         cnt_inc;
		logic                    stop;

		el      = item_s1.err_left;
		er      = item_s1.err_right;
		mrl     = mag_rpm(item_s1.rpm_l);
		mrr     = mag_rpm(item_s1.rpm_r);
		mcl     = mag_cur(item_s1.cur_l);
		mcr     = mag_cur(item_s1.cur_r);
		slim_u  = RpmW'(speed_limit_q);
		slim_s  = $signed(slim_u);
		clim_u  = CurW'(cur_limit_q);
		crit    = either_is(el, er, CodeEncErr) || either_is(el, er, CodeEncTol) ||
			either_is(el, er, CodeVref) || either_is(el, er, CodeHall);
		recov   = either_is(el, er, CodeOverV) || either_is(el, er, CodeUnderV) ||
			either_is(el, er, CodeOverI) || either_is(el, er, CodeOverload) ||
			either_is(el, er, CodeEeprom);
		cnt_inc = (cnt_q == CntMax) ? cnt_q : cnt_q + 1'b1;
		stop    = 1'b0;

		res_d    = '0;
		ovh_d    = ovh_q;
		spd_d    = spd_q;
		cnt_d    = cnt_q;
		halted_d = halted_q;

		if (halted_q) begin
			res_d.halted      = 1'b1;
			res_d.fault_count = cnt_q;
		end else begin
			if ((el != '0) || (er != '0)) begin
				if (crit) begin
					stop = 1'b1;
				end else if (recov) begin
					cnt_d = cnt_inc;
					stop  = (cnt_inc >= rec_limit_q);
				end
				if (stop) begin
					res_d.estop = 1'b1;
					halted_d    = 1'b1;
				end else begin
					if (either_is(el, er, CodeSpeed)) begin
						spd_d           = 1'b1;
						res_d.slow_down = (item_s1.rpm_l > slim_s) ||
							(item_s1.rpm_r > slim_s);
					end
					if (either_is(el, er, CodeHeat)) begin
						ovh_d            = 1'b1;
						res_d.parking_on = (item_s1.temp_l > temp_crit_q) ||
							(item_s1.temp_r > temp_crit_q);
					end
					res_d.reset_and_enable = 1'b1;
				end
			end else begin
				if (spd_q && (mrl < slim_u) && (mrr < slim_u)) begin
					res_d.restore_ramps = 1'b1;
					spd_d               = 1'b0;
				end
				if (ovh_q && (item_s1.temp_l < temp_high_q) &&
					(item_s1.temp_r < temp_high_q)) begin
					res_d.parking_off = 1'b1;
					ovh_d             = 1'b0;
				end
				cnt_d = '0;
			end

			res_d.warn_temperature = (item_s1.temp_l > temp_high_q) ||
				(item_s1.temp_r > temp_high_q) || (item_s1.temp_l < temp_low_q) ||
				(item_s1.temp_r < temp_low_q);
			res_d.warn_speed   = (mrl > slim_u) || (mrr > slim_u);
			res_d.warn_current = (mcl > clim_u) || (mcr > clim_u);

			if (item_s1.publisher_count != PubLegal) begin
				res_d.publisher_stop = 1'b1;
				halted_d             = 1'b1;
			end
			res_d.halted      = halted_d;
			res_d.fault_count = cnt_d;
		end
	end

	assign out_ch.valid            = valid_s2;
	assign out_ch.estop            = res_s2.estop;
	assign out_ch.publisher_stop   = res_s2.publisher_stop;
	assign out_ch.halted           = res_s2.halted;
	assign out_ch.slow_down        = res_s2.slow_down;
	assign out_ch.restore_ramps    = res_s2.restore_ramps;
	assign out_ch.parking_on       = res_s2.parking_on;
	assign out_ch.parking_off      = res_s2.parking_off;
	assign out_ch.reset_and_enable = res_s2.reset_and_enable;
	assign out_ch.warn_temperature = res_s2.warn_temperature;
	assign out_ch.warn_speed       = res_s2.warn_speed;
	assign out_ch.warn_current     = res_s2.warn_current;
	assign out_ch.fault_count      = res_s2.fault_count;

endmodule

/* sim/motor_fault_supervisor_top_tb.sv */
`timescale 1ns / 100ps
// Testbench for motor_fault_supervisor_top: drives monitor ticks and APB register writes,
// and checks every supervisor result against a predictor held in a small scoreboard class.
// Depends on mfs_pkg, the channel interfaces in mfs_if.sv and the top level RTL.
module motor_fault_supervisor_top_tb;
	import mfs_pkg::*;

	class tick_board;
		logic [CntW-1:0]         rec_limit;
		logic [SlimW-1:0]        speed_lim;
		logic signed [TempW-1:0] t_high;
		logic signed [TempW-1:0] t_low;
		logic signed [TempW-1:0] t_crit;
		logic [ClimW-1:0]        cur_lim;
		bit                      heat_lat;
		bit                      speed_lat;
		bit                      halted;
		logic [CntW-1:0]         rec_count;
		out_item_t               want_q[$];
		int                      bad;
		int                      seen;

		function new();
			rec_limit = RstRecLimit;
			speed_lim = RstSpeedLimit;
			t_high = RstTempHigh;
			t_low = RstTempLow;
			t_crit = RstTempCrit;
			cur_lim = RstCurLimit;
			heat_lat = 0;
			speed_lat = 0;
			halted = 0;
			rec_count = '0;
			bad = 0;
			seen = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [DataW-1:0] v);
			case (idx)
				REG_REC_LIMIT: rec_limit = v[CntW-1:0];
				REG_SPEED_LIMIT: speed_lim = v[SlimW-1:0];
				REG_TEMP_HIGH: t_high = v[TempW-1:0];
				REG_TEMP_LOW: t_low = v[TempW-1:0];
				REG_TEMP_CRIT: t_crit = v[TempW-1:0];
				REG_CUR_LIMIT: cur_lim = v[ClimW-1:0];
				default: ;
			endcase
		endfunction

		function bit is_crit(logic [ErrW-1:0] c);
			return c == CodeEncErr || c == CodeEncTol || c == CodeVref || c == CodeHall;
		endfunction

		function bit is_rec(logic [ErrW-1:0] c);
			return c == CodeOverV || c == CodeUnderV || c == CodeOverI || c == CodeOverload ||
				c == CodeEeprom;
		endfunction

		function int mag(int v);
			return v < 0 ? -v : v;
		endfunction

		function void note_tick(in_item_t t);
			out_item_t r;
			int        rl, rr, tl, tr, cl, cr, slim, clim, th, tlo, tc;
			bit        stop;
			r = '0;
			rl = $signed(t.rpm_l);
			rr = $signed(t.rpm_r);
			tl = $signed(t.temp_l);
			tr = $signed(t.temp_r);
			cl = $signed(t.cur_l);
			cr = $signed(t.cur_r);
			slim = int'(speed_lim);
			clim = int'(cur_lim);
			th = t_high;
			tlo = t_low;
			tc = t_crit;
			if (halted) begin
				r.halted = 1'b1;
				r.fault_count = rec_count;
				want_q.push_back(r);
				return;
			end
			if (t.err_left != '0 || t.err_right != '0) begin
				stop = 0;
				if (is_crit(t.err_left) || is_crit(t.err_right)) begin
					stop = 1;
				end else if (is_rec(t.err_left) || is_rec(t.err_right)) begin
					if (rec_count != CntMax)
						rec_count++;
					if (rec_count >= rec_limit)
						stop = 1;
				end
				if (stop) begin
					r.estop = 1'b1;
					halted = 1;
				end else begin
					if (t.err_left == CodeSpeed || t.err_right == CodeSpeed) begin
						speed_lat = 1;
						if (rl > slim || rr > slim)
							r.slow_down = 1'b1;
					end
					if (t.err_left == CodeHeat || t.err_right == CodeHeat) begin
						heat_lat = 1;
						if (tl > tc || tr > tc)
							r.parking_on = 1'b1;
					end
					r.reset_and_enable = 1'b1;
				end
			end else begin
				if (speed_lat && mag(rl) < slim && mag(rr) < slim) begin
					r.restore_ramps = 1'b1;
					speed_lat = 0;
				end
				if (heat_lat && tl < th && tr < th) begin
					r.parking_off = 1'b1;
					heat_lat = 0;
				end
				rec_count = '0;
			end
			r.warn_temperature = tl > th || tr > th || tl < tlo || tr < tlo;
			r.warn_speed = mag(rl) > slim || mag(rr) > slim;
			r.warn_current = mag(cl) > clim || mag(cr) > clim;
			if (t.publisher_count != PubLegal) begin
				r.publisher_stop = 1'b1;
				halted = 1;
			end
			r.halted = halted;
			r.fault_count = rec_count;
			want_q.push_back(r);
		endfunction

		function int cmp(string n, logic [CntW-1:0] e, logic [CntW-1:0] a);
			if (e === a)
				return 0;
			if (bad < 10)
				$display("result %0d %s: expected %0d got %0d", seen, n, e, a);
			return 1;
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			int        diffs;
			seen++;
			if (want_q.size() == 0) begin
				if (bad < 10)
					$display("result %0d arrived with no tick pending: %h", seen, got);
				bad++;
				return;
			end
			want = want_q.pop_front();
			diffs = 0;
			diffs += cmp("estop", want.estop, got.estop);
			diffs += cmp("publisher_stop", want.publisher_stop, got.publisher_stop);
			diffs += cmp("halted", want.halted, got.halted);
			diffs += cmp("slow_down", want.slow_down, got.slow_down);
			diffs += cmp("restore_ramps", want.restore_ramps, got.restore_ramps);
			diffs += cmp("parking_on", want.parking_on, got.parking_on);
			diffs += cmp("parking_off", want.parking_off, got.parking_off);
			diffs += cmp("reset_and_enable", want.reset_and_enable, got.reset_and_enable);
			diffs += cmp("warn_temperature", want.warn_temperature, got.warn_temperature);
			diffs += cmp("warn_speed", want.warn_speed, got.warn_speed);
			diffs += cmp("warn_current", want.warn_current, got.warn_current);
			diffs += cmp("fault_count", want.fault_count, got.fault_count);
			if (diffs != 0)
				bad++;
		endfunction

		function int pending();
			return want_q.size();
		endfunction

		function bit clean();
			return bad == 0 && want_q.size() == 0;
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;
	bit               calm;
	bit               stall_req;
	tick_board        sb;

	mfs_in_if  in_ch();
	mfs_out_if out_ch();

	motor_fault_supervisor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #2 clk = ~clk;

	function automatic int span(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic int around(int c, int lo, int hi);
		int v;
		v = c + int'($urandom_range(6)) - 3;
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return v;
	endfunction

	function automatic logic [ErrW-1:0] code_at(int i);
		case (i)
			0: return CodeEncErr;
			1: return CodeEncTol;
			2: return CodeVref;
			3: return CodeHall;
			4: return CodeOverV;
			5: return CodeUnderV;
			6: return CodeOverI;
			7: return CodeOverload;
			8: return CodeEeprom;
			9: return CodeSpeed;
			default: return CodeHeat;
		endcase
	endfunction

	function automatic in_item_t mk(logic [ErrW-1:0] el, logic [ErrW-1:0] er, int rl, int rr,
		int tl, int tr, int cl, int cr, int pubs);
		in_item_t t;
		t.err_left = el;
		t.err_right = er;
		t.rpm_l = RpmW'(rl);
		t.rpm_r = RpmW'(rr);
		t.temp_l = TempW'(tl);
		t.temp_r = TempW'(tr);
		t.cur_l = CurW'(cl);
		t.cur_r = CurW'(cr);
		t.publisher_count = PubW'(pubs);
		return t;
	endfunction

	function automatic logic [ErrW-1:0] healthy_code(bit rec_ok);
		logic [ErrW-1:0] c;
		case ($urandom_range(7))
			0, 1, 2: c = '0;
			3: c = CodeSpeed;
			4: c = CodeHeat;
			5: c = rec_ok ? code_at(span(4, 8)) : '0;
			default: begin
				c = ErrW'($urandom);
				while (sb.is_crit(c) || sb.is_rec(c))
					c = ErrW'($urandom);
			end
		endcase
		return c;
	endfunction

	function automatic int pick_rpm(int slim);
		case ($urandom_range(3))
			0: return span(-4096, 4095);
			1: return around(slim, -4096, 4095);
			2: return around(-slim, -4096, 4095);
			default: return span(-slim, slim);
		endcase
	endfunction

	function automatic int pick_temp(int th, int tlo, int tc);
		case ($urandom_range(3))
			0: return span(-128, 127);
			1: return around(th, -128, 127);
			2: return around(tlo, -128, 127);
			default: return around(tc, -128, 127);
		endcase
	endfunction

	function automatic int pick_cur(int clim);
		case ($urandom_range(6))
			0, 1: return span(-400, 400);
			2, 3: return around(clim, -512, 511);
			4, 5: return around(-clim, -512, 511);
			default: return span(-512, 511);
		endcase
	endfunction

	function automatic in_item_t healthy_tick();
		logic [ErrW-1:0] el, er;
		bit              rec_ok;
		int              slim, th, tlo, tc, clim;
		rec_ok = int'(sb.rec_count) + 1 < int'(sb.rec_limit);
		if ($urandom_range(99) < 40) begin
			el = '0;
			er = '0;
		end else begin
			el = healthy_code(rec_ok);
			er = healthy_code(rec_ok);
		end
		slim = int'(sb.speed_lim);
		clim = int'(sb.cur_lim);
		th = sb.t_high;
		tlo = sb.t_low;
		tc = sb.t_crit;
		return mk(el, er, pick_rpm(slim), pick_rpm(slim), pick_temp(th, tlo, tc),
			pick_temp(th, tlo, tc), pick_cur(clim), pick_cur(clim), PubLegal);
	endfunction

	function automatic in_item_t halt_tick(int kind);
		in_item_t t;
		t = healthy_tick();
		if (kind == 0 || kind == 3) begin
			if ($urandom_range(1))
				t.err_left = code_at(span(0, 3));
			else
				t.err_right = code_at(span(0, 3));
		end
		if (kind == 1) begin
			t.err_left = code_at(span(4, 8));
			t.err_right = $urandom_range(1) ? code_at(span(9, 10)) : '0;
		end
		if (kind >= 2) begin
			t.publisher_count = PubW'(span(0, 15));
			while (t.publisher_count == PubLegal)
				t.publisher_count = PubW'(span(0, 15));
		end
		return t;
	endfunction

	function automatic in_item_t noise_tick();
		logic [127:0] raw;
		in_item_t     t;
		raw = {$urandom, $urandom, $urandom, $urandom};
		t = raw[$bits(in_item_t)-1:0];
		if ($urandom_range(1))
			t.err_left = code_at(span(0, 10));
		if ($urandom_range(1))
			t.err_right = code_at(span(0, 10));
		return t;
	endfunction

	task automatic put_fields(in_item_t t);
		in_ch.err_left = t.err_left;
		in_ch.err_right = t.err_right;
		in_ch.rpm_l = t.rpm_l;
		in_ch.rpm_r = t.rpm_r;
		in_ch.temp_l = t.temp_l;
		in_ch.temp_r = t.temp_r;
		in_ch.cur_l = t.cur_l;
		in_ch.cur_r = t.cur_r;
		in_ch.publisher_count = t.publisher_count;
	endtask

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_tick(in_item_t t);
		while (!calm && $urandom_range(99) < 31) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		put_fields(t);
		in_ch.valid = 1'b1;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_tick(t);
		@(negedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, int v);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = AddrW'(int'(idx) * 4);
		pwdata = DataW'(v);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.write_reg(idx, DataW'(v));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic write_set(int lim, int slim, int th, int tlo, int tc, int clim);
		apb_write(REG_REC_LIMIT, lim & 7);
		apb_write(REG_SPEED_LIMIT, slim & 'hFFF);
		apb_write(REG_TEMP_HIGH, th & 'hFF);
		apb_write(REG_TEMP_LOW, tlo & 'hFF);
		apb_write(REG_TEMP_CRIT, tc & 'hFF);
		apb_write(REG_CUR_LIMIT, clim & 'h1FF);
	endtask

	// drop valid and wait out every pending result
	task automatic drain();
		in_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// receiver: random ready, with a long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_req = 0;
				out_ch.ready = 1'b0;
				repeat (80)
					@(negedge clk);
			end
			out_ch.ready = calm || $urandom_range(99) >= 31;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result({out_ch.estop, out_ch.publisher_stop, out_ch.halted,
				out_ch.slow_down, out_ch.restore_ramps, out_ch.parking_on,
				out_ch.parking_off, out_ch.reset_and_enable, out_ch.warn_temperature,
				out_ch.warn_speed, out_ch.warn_current, out_ch.fault_count});
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int kind;
		sb = new();
		calm = 0;
		stall_req = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		put_fields(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed ticks at reset thresholds
		send_tick(mk(0, 0, 0, 0, 70, 70, 0, 0, 1));
		send_tick(mk(0, 0, 4095, -4096, 127, -128, 400, -400, 1));
		send_tick(mk(0, 0, -4096, 4095, -128, 127, 511, -512, 1));
		send_tick(mk(16'hFFFF, 0, 2500, -2500, 85, 60, 250, -250, 1));
		send_tick(mk(CodeSpeed, 0, 2501, 0, 70, 70, 0, 0, 1));
		send_tick(mk(0, 0, 2499, -2499, 70, 70, 0, 0, 1));
		send_tick(mk(0, CodeSpeed, -3000, 100, 70, 70, 0, 0, 1));
		send_tick(mk(0, 0, 2500, 0, 70, 70, 0, 0, 1));
		send_tick(mk(0, 0, 0, 0, 70, 70, 0, 0, 1));
		send_tick(mk(CodeHeat, 0, 0, 0, 101, 50, 0, 0, 1));
		send_tick(mk(0, 0, 0, 0, 85, 70, 0, 0, 1));
		send_tick(mk(0, 0, 0, 0, 84, 84, 0, 0, 1));
		send_tick(mk(0, CodeHeat, 0, 0, 100, 100, 0, 0, 1));
		send_tick(mk(CodeSpeed, CodeHeat, 3000, 0, 110, 0, 251, 0, 1));
		send_tick(mk(0, 0, 0, 0, 70, 70, 0, 0, 1));
		send_tick(mk(CodeOverV, 0, 0, 0, 70, 70, 0, 0, 1));
		send_tick(mk(0, CodeUnderV, 0, 0, 70, 70, 0, 0, 1));
		send_tick(mk(CodeOverI, CodeSpeed, 2600, 0, 70, 70, 0, 0, 1));
		send_tick(mk(CodeOverload, CodeHeat, 0, 0, 120, 70, 0, 0, 1));
		send_tick(mk(0, 0, 0, 0, 70, 70, 0, 0, 1));
		send_tick(mk(CodeEeprom, CodeEeprom, 0, 0, 70, 70, 0, 0, 1));
		send_tick(mk(16'h4000, 16'h0010, 0, 0, 70, 70, 0, 0, 1));
		send_tick(mk(0, 0, 0, 0, 70, 70, 0, 0, 1));

		for (int p = 0; p < 5; p++) begin
			drain();
			case (p)
				0: write_set(7, 4095, 127, -128, 127, 400);
				1: write_set(1, 0, -128, 127, -128, 0);
				2: write_set(0, span(0, 4095), span(-128, 127), span(-128, 127),
					span(-128, 127), span(0, 400));
				3: write_set(3, 1000, 40, -20, 70, 100);
				default: write_set(span(2, 7), span(0, 4095), span(-128, 127),
					span(-128, 127), span(-128, 127), span(0, 400));
			endcase
			calm = p == 3;
			for (int i = 0; i < 190; i++) begin
				if (p == 4 && i % 60 == 20)
					stall_req = 1;
				send_tick(healthy_tick());
			end
		end

		// last phase: halt once, then keep ticking against the frozen state
		drain();
		calm = 0;
		write_set(span(0, 7), span(0, 4095), span(-128, 127), span(-128, 127),
			span(-128, 127), span(0, 400));
		for (int i = 0; i < 10; i++)
			send_tick(healthy_tick());
		kind = span(0, 3);
		do
			send_tick(halt_tick(kind));
		while (!sb.halted);
		for (int i = 0; i < 40; i++)
			send_tick(noise_tick());

		in_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (sb.clean())
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
